### design/bfd_pkg.sv
// bfd_pkg: shared types and constants for the preamble framed deframer
// holds the phase enum, result kind codes and preamble constants
// no dependencies
package bfd_pkg;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CHECK   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_SUM_OK   = 2'd1,
        KIND_SUM_BAD  = 2'd2,
        KIND_BAD_LEN  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [31:0] data_word;
        logic [15:0] word_index;
        logic [15:0] msg_code;
    } out_data_t;

    // bytes per frame word
    localparam int WORD_BYTES = 4;

    // "GEOSr3PS", first byte in the top byte
    localparam logic [63:0] PREAMBLE = 64'h4745_4F53_7233_5053;
    // xor of the two little-endian preamble words
    localparam logic [31:0] PREAMBLE_XOR = 32'h534F_4547 ^ 32'h5350_3372;

    localparam logic [15:0] MAX_WORDS_RESET = 16'd253;

    localparam logic       ADDR_MAX_WORDS = 1'b0;

endpackage

### design/binary_frame_deframer_xor32_top.sv
// Byte stream deframer: hunts for the exact preamble "GEOSr3PS", then assembles
// little-endian 32-bit words (header, payload, checksum) and reports each
// payload word and one status beat per frame. One input beat is taken per
// cycle: each beat is held in an input register until the result register can
// take its outcome, and is processed by a single pass of shift, xor and counter
// logic into the result register, so throughput is one byte per clock while
// the result side keeps up; a stalled result holds the input register.
// The payload limit register lies at byte address 0 of the APB port.
// depends on bfd_pkg
module binary_frame_deframer_xor32_top (
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // rx_byte
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // msg_code[15:0], word_index[31:16], data_word[63:32]
    output logic [1:0]  m_tuser,    // out_kind
    output logic        m_tlast,    // last
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int BIW_W = $clog2(bfd_pkg::WORD_BYTES);
    localparam logic [BIW_W-1:0] BIW_LAST = BIW_W'(bfd_pkg::WORD_BYTES - 1);

    logic [15:0] max_words_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    logic                 out_valid_reg, out_valid_next;
    bfd_pkg::out_data_t   out_data_reg, out_data_next;
    bfd_pkg::kind_t       out_kind_reg, out_kind_next;
    logic                 out_last_reg, out_last_next;

    logic [63:0]          shift_reg, shift_next;
    bfd_pkg::phase_t      phase_reg, phase_next;
    logic [BIW_W-1:0]     biw_reg, biw_next;
    logic [31:0]          asm_reg, asm_next;
    logic [31:0]          xor_reg, xor_next;
    logic [15:0]          ftype_reg, ftype_next;
    logic [15:0]          flen_reg, flen_next;
    logic [15:0]          wcnt_reg, wcnt_next;

    logic        advance;
    logic        emit;
    logic [31:0] word;
    logic [15:0] wcnt_inc;

    // config port
    assign pready = 1'b1;
    assign prdata = {16'd0, max_words_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_words_reg <= bfd_pkg::MAX_WORDS_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == bfd_pkg::ADDR_MAX_WORDS)
        begin
            max_words_reg <= pwdata[15:0];
        end
    end

    // handshakes
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // word as completed by the current byte
    always_comb
    begin
        word = asm_reg;
        word[31:24] = in_byte_reg;
    end

    assign wcnt_inc = wcnt_reg + 16'd1;

    always_comb
    begin
        shift_next    = shift_reg;
        phase_next    = phase_reg;
        biw_next      = biw_reg;
        asm_next      = asm_reg;
        xor_next      = xor_reg;
        ftype_next    = ftype_reg;
        flen_next     = flen_reg;
        wcnt_next     = wcnt_reg;
        emit          = 1'b0;
        out_kind_next = out_kind_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;

        if (phase_reg == bfd_pkg::PH_HUNT)
        begin
            shift_next = {shift_reg[55:0], in_byte_reg};
            if (shift_next == bfd_pkg::PREAMBLE)
            begin
                phase_next = bfd_pkg::PH_HEADER;
                xor_next   = bfd_pkg::PREAMBLE_XOR;
                biw_next   = '0;
                asm_next   = '0;
                wcnt_next  = '0;
            end
        end
        else if (biw_reg != BIW_LAST)
        begin
            asm_next[{biw_reg, 3'b000} +: 8] = in_byte_reg;
            biw_next = biw_reg + BIW_W'(1);
        end
        else
        begin
            biw_next = '0;
            asm_next = '0;
            case (phase_reg)
                bfd_pkg::PH_HEADER:
                begin
                    ftype_next = word[15:0];
                    flen_next  = word[31:16];
                    if (word[31:16] == 16'd0 || word[31:16] > max_words_reg)
                    begin
                        emit          = 1'b1;
                        out_kind_next = bfd_pkg::KIND_BAD_LEN;
                        out_data_next = '{data_word: word, word_index: word[31:16],
                                          msg_code: word[15:0]};
                        out_last_next = 1'b1;
                        phase_next    = bfd_pkg::PH_HUNT;
                        shift_next    = '0;
                    end
                    else
                    begin
                        xor_next   = xor_reg ^ word;
                        wcnt_next  = '0;
                        phase_next = bfd_pkg::PH_PAYLOAD;
                    end
                end
                bfd_pkg::PH_PAYLOAD:
                begin
                    xor_next      = xor_reg ^ word;
                    emit          = 1'b1;
                    out_kind_next = bfd_pkg::KIND_PAYLOAD;
                    out_data_next = '{data_word: word, word_index: wcnt_reg,
                                      msg_code: ftype_reg};
                    out_last_next = 1'b0;
                    wcnt_next     = wcnt_inc;
                    if (wcnt_inc == flen_reg)
                    begin
                        phase_next = bfd_pkg::PH_CHECK;
                    end
                end
                default:
                begin
                    emit          = 1'b1;
                    out_kind_next = (xor_reg == word) ? bfd_pkg::KIND_SUM_OK
                                                      : bfd_pkg::KIND_SUM_BAD;
                    out_data_next = '{data_word: word, word_index: flen_reg,
                                      msg_code: ftype_reg};
                    out_last_next = 1'b1;
                    phase_next    = bfd_pkg::PH_HUNT;
                    shift_next    = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = emit;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            shift_reg     <= '0;
            phase_reg     <= bfd_pkg::PH_HUNT;
            biw_reg       <= '0;
            asm_reg       <= '0;
            xor_reg       <= '0;
            ftype_reg     <= '0;
            flen_reg      <= '0;
            wcnt_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                shift_reg <= shift_next;
                phase_reg <= phase_next;
                biw_reg   <= biw_next;
                asm_reg   <= asm_next;
                xor_reg   <= xor_next;
                ftype_reg <= ftype_next;
                flen_reg  <= flen_next;
                wcnt_reg  <= wcnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_kind_reg <= out_kind_next;
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
